// ----- hw/rtl/l3dt_pkg.sv -----
// Package for the 3D LUT color grader with shaper.
// Holds sizes, command and register codes, and the structs shared by all modules.
package l3dt_pkg;

  localparam int PIX_W              = 24;
  localparam int FRAC_BITS          = 16;
  localparam int SHAPER_SCALE_FRAC  = 8;
  localparam int SHAPER_ENTRIES_MAX = 4096;
  localparam int SHAPER_AW          = $clog2(SHAPER_ENTRIES_MAX);
  localparam int SHAPER_LANES       = 3;
  localparam int CUBE_POINTS_MAX    = 33;
  localparam int CUBE_DEPTH         = CUBE_POINTS_MAX * CUBE_POINTS_MAX * CUBE_POINTS_MAX;
  localparam int CUBE_AW            = $clog2(CUBE_DEPTH);
  localparam int PTS_W              = 6;
  localparam int TIDX_W             = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 60;

  localparam logic [FRAC_BITS:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_CUBE_WR   = 2'd1,
    CMD_SHAPER_WR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_CUBE_WR,
    KIND_SHAPER_WR
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_LUT_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPER_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DSCALE_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DSCALE_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DSCALE_BLUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPER_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPER_SCALE = 3'd6;

  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef struct packed {
    logic [PTS_W-1:0]  lut_size;
    logic [12:0]       shaper_size;
    logic [2:0][23:0]  dscale;
    logic [59:0]       smin;
    logic [59:0]       sscale;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    pix3_t              pix;
    logic [PIX_W-1:0]   alpha;
    logic [TIDX_W-1:0]  tidx;
    logic [1:0]         ch;
    pix3_t              entry;
    logic [PIX_W-1:0]   shval;
  } item_t;

endpackage

// ----- hw/rtl/lut3d_tetrahedral_with_shaper.sv -----
// Top level of the 3D LUT color grader: configuration registers and pipeline wiring.
// Depends on l3dt_pkg, l3dt_front, l3dt_queue, l3dt_shaper and l3dt_cube.
//
// Takes one request per clock while in_stall_o is low and returns a graded pixel for
// each pixel request (the queue slot is written at the accepting edge, then the request
// passes thirteen pipeline registers, the last being the output register); table
// writes give no result and pass the same pipeline so they stay in order with pixels.
// The rate is set by the cube lookup: four entries per pixel are read from two copies
// of the cube table with two read ports each, and the shaper tables are read at two
// points per channel. Tables are not cleared at reset; load every entry before use.
// A stall on the output holds the whole pipeline; the two-entry queue absorbs it.
module lut3d_tetrahedral_with_shaper import l3dt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      blue_i,
  input  logic [PIX_W-1:0]      alpha_i,
  input  logic [TIDX_W-1:0]     table_index_i,
  input  logic [1:0]            shaper_channel_i,
  input  logic [PIX_W-1:0]      entry_red_i,
  input  logic [PIX_W-1:0]      entry_green_i,
  input  logic [PIX_W-1:0]      entry_blue_i,
  input  logic [PIX_W-1:0]      shaper_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [PIX_W-1:0]      out_alpha_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  adv;
  logic  full, push, q_valid;
  item_t push_item, q_item, sh_item;
  logic  sh_valid;
  pix3_t sh_pix, out_pix;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lut_size    <= PTS_W'(CUBE_POINTS_MAX);
      cfg_q.shaper_size <= '0;
      cfg_q.dscale      <= {3{24'(FX_ONE)}};
      cfg_q.smin        <= '0;
      cfg_q.sscale      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LUT_SIZE:     cfg_q.lut_size    <= cfg_data_i[PTS_W-1:0];
        REG_SHAPER_SIZE:  cfg_q.shaper_size <= cfg_data_i[12:0];
        REG_DSCALE_RED:   cfg_q.dscale[0]   <= cfg_data_i[23:0];
        REG_DSCALE_GREEN: cfg_q.dscale[1]   <= cfg_data_i[23:0];
        REG_DSCALE_BLUE:  cfg_q.dscale[2]   <= cfg_data_i[23:0];
        REG_SHAPER_MIN:   cfg_q.smin        <= cfg_data_i;
        REG_SHAPER_SCALE: cfg_q.sscale      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  l3dt_front u_front (
    .in_valid_i       (in_valid_i),
    .command_i        (command_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .alpha_i          (alpha_i),
    .table_index_i    (table_index_i),
    .shaper_channel_i (shaper_channel_i),
    .entry_red_i      (entry_red_i),
    .entry_green_i    (entry_green_i),
    .entry_blue_i     (entry_blue_i),
    .shaper_value_i   (shaper_value_i),
    .full_i           (full),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .item_o           (push_item)
  );

  l3dt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (adv),
    .valid_o (q_valid),
    .item_o  (q_item),
    .full_o  (full)
  );

  l3dt_shaper u_shaper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .item_i  (q_item),
    .valid_o (sh_valid),
    .item_o  (sh_item),
    .pix_o   (sh_pix)
  );

  l3dt_cube u_cube (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .valid_i     (sh_valid),
    .item_i      (sh_item),
    .pix_i       (sh_pix),
    .out_valid_o (out_valid_o),
    .out_pix_o   (out_pix),
    .out_alpha_o (out_alpha_o)
  );

  assign out_red_o   = out_pix[0];
  assign out_green_o = out_pix[1];
  assign out_blue_o  = out_pix[2];

endmodule

// ----- hw/rtl/l3dt_front.sv -----
// Front end: classifies incoming requests and drops the ones that do nothing.
// Depends on l3dt_pkg.
module l3dt_front import l3dt_pkg::*; (
  input  logic              in_valid_i,
  input  logic [1:0]        command_i,
  input  logic [PIX_W-1:0]  red_i,
  input  logic [PIX_W-1:0]  green_i,
  input  logic [PIX_W-1:0]  blue_i,
  input  logic [PIX_W-1:0]  alpha_i,
  input  logic [TIDX_W-1:0] table_index_i,
  input  logic [1:0]        shaper_channel_i,
  input  logic [PIX_W-1:0]  entry_red_i,
  input  logic [PIX_W-1:0]  entry_green_i,
  input  logic [PIX_W-1:0]  entry_blue_i,
  input  logic [PIX_W-1:0]  shaper_value_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output item_t             item_o
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    item_o.kind = KIND_PIXEL;
    case (cmd_e'(command_i))
      CMD_PIXEL: begin
        keep = 1'b1;
      end
      CMD_CUBE_WR: begin
        item_o.kind = KIND_CUBE_WR;
        keep = 32'(table_index_i) < CUBE_DEPTH;
      end
      CMD_SHAPER_WR: begin
        item_o.kind = KIND_SHAPER_WR;
        keep = (32'(shaper_channel_i) < SHAPER_LANES) &&
               (32'(table_index_i) < SHAPER_ENTRIES_MAX);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    item_o.pix   = {blue_i, green_i, red_i};
    item_o.alpha = alpha_i;
    item_o.tidx  = table_index_i;
    item_o.ch    = shaper_channel_i;
    item_o.entry = {entry_blue_i, entry_green_i, entry_red_i};
    item_o.shval = shaper_value_i;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

// ----- hw/rtl/l3dt_queue.sv -----
// Two-entry request queue between the front end and the processing pipeline.
// Depends on l3dt_pkg.
module l3dt_queue import l3dt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o,
  output logic  full_o
);

  item_t      buf_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign item_o  = buf_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

// ----- hw/rtl/l3dt_shaper.sv -----
// Shaper pipeline: offset, scale and 1D table interpolation per channel.
// Holds the three shaper tables. Depends on l3dt_pkg.
module l3dt_shaper import l3dt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o,
  output pix3_t pix_o
);

  logic [4:0]           vld_q;
  item_t                it_q [5];
  logic [12:0]          ssz;
  logic [SHAPER_AW-1:0] top_s;
  logic                 shen;

  always_comb begin
    ssz   = (cfg_i.shaper_size > 13'(SHAPER_ENTRIES_MAX)) ?
            13'(SHAPER_ENTRIES_MAX) : cfg_i.shaper_size;
    top_s = SHAPER_AW'(ssz - 13'd1);
    shen  = ssz != 13'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0] <= item_i;
      for (int i = 1; i < 5; i++) begin
        it_q[i] <= it_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[4];
  assign item_o  = it_q[4];

  for (genvar k = 0; k < SHAPER_LANES; k++) begin : g_lane
    logic signed [19:0]              mn;
    logic [19:0]                     sc;
    logic signed [24:0]              diff_q;
    logic signed [45:0]              sprod_q;
    logic signed [37:0]              sh;
    logic [SHAPER_AW+FRAC_BITS-1:0]  cap;
    logic [SHAPER_AW+FRAC_BITS-1:0]  x;
    logic [SHAPER_AW-1:0]            lo;
    logic [SHAPER_AW-1:0]            hi;
    logic [PIX_W-1:0]                mem [SHAPER_ENTRIES_MAX];
    logic [PIX_W-1:0]                rdp_q, rdn_q, p4_q, pix_q;
    logic [FRAC_BITS-1:0]            d3_q;
    logic signed [41:0]              lerp_q;
    logic signed [41:0]              rsum;
    logic                            wen;

    assign mn = cfg_i.smin[20*k +: 20];
    assign sc = cfg_i.sscale[20*k +: 20];

    always_comb begin
      sh  = 38'(sprod_q >>> SHAPER_SCALE_FRAC);
      cap = {top_s, {FRAC_BITS{1'b0}}};
      x   = '0;
      if (sprod_q > 46'sd0) begin
        if (sh > $signed({10'd0, cap})) begin
          x = cap;
        end else begin
          x = sh[SHAPER_AW+FRAC_BITS-1:0];
        end
      end
      lo   = x[SHAPER_AW+FRAC_BITS-1:FRAC_BITS];
      hi   = (lo == top_s) ? lo : lo + 1'b1;
      wen  = vld_q[1] && (it_q[1].kind == KIND_SHAPER_WR) && (32'(it_q[1].ch) == k);
      rsum = (lerp_q + 42'sd32768) >>> FRAC_BITS;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        diff_q  <= 25'($signed(item_i.pix[k])) - 25'(mn);
        sprod_q <= diff_q * $signed({1'b0, sc});
        if (wen) begin
          mem[it_q[1].tidx[SHAPER_AW-1:0]] <= it_q[1].shval;
        end
        rdp_q  <= mem[lo];
        rdn_q  <= mem[hi];
        d3_q   <= x[FRAC_BITS-1:0];
        lerp_q <= (25'($signed(rdn_q)) - 25'($signed(rdp_q))) * $signed({1'b0, d3_q});
        p4_q   <= rdp_q;
        pix_q  <= shen ? (p4_q + rsum[PIX_W-1:0]) : it_q[3].pix[k];
      end
    end

    assign pix_o[k] = pix_q;
  end

endmodule

// ----- hw/rtl/l3dt_cube.sv -----
// Cube pipeline: domain scaling, lattice lookup, tetrahedral blend, output register.
// Holds two copies of the cube table for four reads a cycle. Depends on l3dt_pkg.
module l3dt_cube import l3dt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  pix3_t            pix_i,
  output logic             out_valid_o,
  output pix3_t            out_pix_o,
  output logic [PIX_W-1:0] out_alpha_o
);

  localparam int CW = 3 * PIX_W;

  logic [6:0]          vld_q;
  item_t               it_q [7];
  logic [PTS_W-1:0]    n_c, top_c;
  logic [10:0]         nn;
  logic [10:0]         stride [3];

  logic signed [48:0]  cp1_q [3];
  logic signed [55:0]  cp2_q [3];
  logic signed [39:0]  sh [3];
  logic [21:0]         cap;
  logic [21:0]         x [3];
  logic [PTS_W-1:0]    p8_q [3], hp8_q [3];
  logic [FRAC_BITS-1:0] d8_q [3];
  logic [CUBE_AW-1:0]  lo9_q [3], hi9_q [3];
  logic                gr9_q, gg9_q, gb9_q;
  logic [FRAC_BITS:0]  w9_q [4], w10_q [4];
  logic [FRAC_BITS:0]  w [4];
  logic                gr, gg, gb;
  logic [FRAC_BITS-1:0] rgmin, rgmax, mid, x0, x1, x2;
  logic [CUBE_AW-1:0]  i0, ia, ib, i1;
  logic [CW-1:0]       cmem_a [CUBE_DEPTH];
  logic [CW-1:0]       cmem_b [CUBE_DEPTH];
  logic [CW-1:0]       c10_q [4];
  logic                cwen;
  logic signed [41:0]  prod_q [4][3];
  logic signed [42:0]  sum_q [2][3];
  logic signed [43:0]  acc [3];
  logic                out_valid_q;
  pix3_t               out_pix_q;
  logic [PIX_W-1:0]    out_alpha_q;

  always_comb begin
    if (cfg_i.lut_size < PTS_W'(2)) begin
      n_c = PTS_W'(2);
    end else if (cfg_i.lut_size > PTS_W'(CUBE_POINTS_MAX)) begin
      n_c = PTS_W'(CUBE_POINTS_MAX);
    end else begin
      n_c = cfg_i.lut_size;
    end
    top_c     = n_c - 1'b1;
    nn        = 11'(n_c) * 11'(n_c);
    stride[0] = nn;
    stride[1] = 11'(n_c);
    stride[2] = 11'd1;
    cap       = {top_c, {FRAC_BITS{1'b0}}};
    for (int k = 0; k < 3; k++) begin
      sh[k] = 40'(cp2_q[k] >>> FRAC_BITS);
      x[k]  = '0;
      if (cp2_q[k] > 56'sd0) begin
        if (sh[k] > $signed({18'd0, cap})) begin
          x[k] = cap;
        end else begin
          x[k] = sh[k][21:0];
        end
      end
    end
  end

  always_comb begin
    gr    = d8_q[0] > d8_q[1];
    gg    = d8_q[1] > d8_q[2];
    gb    = d8_q[2] > d8_q[0];
    rgmin = (d8_q[0] < d8_q[1]) ? d8_q[0] : d8_q[1];
    rgmax = (d8_q[0] < d8_q[1]) ? d8_q[1] : d8_q[0];
    x2    = (rgmin < d8_q[2]) ? rgmin : d8_q[2];
    mid   = (rgmin < d8_q[2]) ? d8_q[2] : rgmin;
    x0    = (rgmax < d8_q[2]) ? d8_q[2] : rgmax;
    x1    = (rgmax < mid) ? rgmax : mid;
    w[0]  = FX_ONE - {1'b0, x0};
    w[1]  = {1'b0, x0} - {1'b0, x1};
    w[2]  = {1'b0, x1} - {1'b0, x2};
    w[3]  = {1'b0, x2};
  end

  always_comb begin
    i0 = lo9_q[0] + lo9_q[1] + lo9_q[2];
    i1 = hi9_q[0] + hi9_q[1] + hi9_q[2];
    ia = ((!gb9_q && gr9_q) ? hi9_q[0] : lo9_q[0]) +
         ((!gr9_q && gg9_q) ? hi9_q[1] : lo9_q[1]) +
         ((!gg9_q && gb9_q) ? hi9_q[2] : lo9_q[2]);
    ib = ((!gr9_q && gb9_q) ? lo9_q[0] : hi9_q[0]) +
         ((!gg9_q && gr9_q) ? lo9_q[1] : hi9_q[1]) +
         ((!gb9_q && gg9_q) ? lo9_q[2] : hi9_q[2]);
    cwen = vld_q[3] && (it_q[3].kind == KIND_CUBE_WR);
    for (int k = 0; k < 3; k++) begin
      acc[k] = 44'(sum_q[0][k]) + 44'(sum_q[1][k]) + 44'sd32768;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      vld_q       <= {vld_q[5:0], valid_i};
      out_valid_q <= vld_q[6] && (it_q[6].kind == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0] <= item_i;
      for (int i = 1; i < 7; i++) begin
        it_q[i] <= it_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        cp1_q[k] <= $signed(pix_i[k]) * $signed({1'b0, cfg_i.dscale[k]});
        cp2_q[k] <= cp1_q[k] * $signed({1'b0, top_c});
        p8_q[k]  <= x[k][21:16];
        hp8_q[k] <= (x[k][21:16] == top_c) ? top_c : x[k][21:16] + 1'b1;
        d8_q[k]  <= x[k][FRAC_BITS-1:0];
        lo9_q[k] <= CUBE_AW'(CUBE_AW'(p8_q[k]) * CUBE_AW'(stride[k]));
        hi9_q[k] <= CUBE_AW'(CUBE_AW'(hp8_q[k]) * CUBE_AW'(stride[k]));
      end
      gr9_q <= gr;
      gg9_q <= gg;
      gb9_q <= gb;
      w9_q  <= w;
      w10_q <= w9_q;
      for (int t = 0; t < 4; t++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[t][k] <= $signed({1'b0, w10_q[t]}) * $signed(c10_q[t][PIX_W*k +: PIX_W]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        sum_q[0][k]  <= 43'(prod_q[0][k]) + 43'(prod_q[1][k]);
        sum_q[1][k]  <= 43'(prod_q[2][k]) + 43'(prod_q[3][k]);
        out_pix_q[k] <= acc[k][FRAC_BITS +: PIX_W];
      end
      out_alpha_q <= it_q[6].alpha;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (cwen) begin
        cmem_a[it_q[3].tidx] <= it_q[3].entry;
        cmem_b[it_q[3].tidx] <= it_q[3].entry;
      end
      c10_q[0] <= cmem_a[i0];
      c10_q[1] <= cmem_a[ia];
      c10_q[2] <= cmem_b[ib];
      c10_q[3] <= cmem_b[i1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_alpha_o = out_alpha_q;

endmodule

// ----- bench/tb_lut3d_tetrahedral_with_shaper.sv -----
// Self-checking bench for lut3d_tetrahedral_with_shaper: loads both tables, steps the
// config through several settings, and checks every graded pixel against a local model.
// Depends on l3dt_pkg and the lut3d_tetrahedral_with_shaper RTL.
`timescale 1ns / 1ps

module tb_lut3d_tetrahedral_with_shaper;
  import l3dt_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [1:0]  cmd;
    logic [23:0] r, g, b, a;
    logic [15:0] tidx;
    logic [1:0]  ch;
    logic [23:0] er, eg, eb, sv;
  } request_t;

  typedef struct {
    logic [23:0] r, g, b, a;
  } graded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [23:0] red = '0, green = '0, blue = '0, alpha = '0;
  logic [15:0] table_index = '0;
  logic [1:0] shaper_channel = '0;
  logic [23:0] entry_red = '0, entry_green = '0, entry_blue = '0, shaper_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  request_t pending_q[$];
  graded_t graded_q[$];
  request_t cur;
  int send_idle = 0, recv_idle = 0;
  int errors = 0;
  int hold_req = 0, hold_done = 0, hold_left = 0;
  int cycles = 0;

  logic [5:0]  m_lut = 6'd33;
  logic [12:0] m_ssz = '0;
  logic [23:0] m_ds[3] = '{24'd65536, 24'd65536, 24'd65536};
  logic [59:0] m_smin = '0, m_ssc = '0;
  logic [23:0] cube_r[CUBE_DEPTH], cube_g[CUBE_DEPTH], cube_b[CUBE_DEPTH];
  logic [23:0] shaper_tab[3][SHAPER_ENTRIES_MAX];

  lut3d_tetrahedral_with_shaper DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .red_i(red), .green_i(green), .blue_i(blue), .alpha_i(alpha),
    .table_index_i(table_index), .shaper_channel_i(shaper_channel),
    .entry_red_i(entry_red), .entry_green_i(entry_green), .entry_blue_i(entry_blue),
    .shaper_value_i(shaper_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .out_alpha_o(out_alpha),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint sx24(logic [23:0] a);
    return longint'($signed(a));
  endfunction

  function automatic longint round16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic graded_t grade_pixel(request_t q);
    graded_t res;
    longint v[3], lo[3], hi[3], d[3], stride[3], idx[4], w[4], acc[3];
    longint mn, sc, prod, top, x, l, h, p, nx, ssz, n;
    longint rgmin, rgmax, x0, x1, x2, mid, i0, i1, ia, ib;
    logic gr, gg, gb;
    v[0] = sx24(q.r);
    v[1] = sx24(q.g);
    v[2] = sx24(q.b);
    ssz = (m_ssz > 13'd4096) ? 4096 : longint'(m_ssz);
    if (ssz != 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        mn = longint'($signed(m_smin[20*ch +: 20]));
        sc = longint'(m_ssc[20*ch +: 20]);
        prod = (v[ch] - mn) * sc;
        top = ssz - 1;
        x = 0;
        if (prod > 0) begin
          x = prod >>> SHAPER_SCALE_FRAC;
          if (x > (top <<< 16)) x = top <<< 16;
        end
        l = x >>> 16;
        h = (l + 1 > top) ? top : l + 1;
        p = sx24(shaper_tab[ch][l]);
        nx = sx24(shaper_tab[ch][h]);
        v[ch] = p + round16((nx - p) * (x & 64'hFFFF));
      end
    end
    n = longint'(m_lut);
    if (n < 2) n = 2;
    if (n > CUBE_POINTS_MAX) n = CUBE_POINTS_MAX;
    top = n - 1;
    stride[0] = n * n;
    stride[1] = n;
    stride[2] = 1;
    for (int k = 0; k < 3; k++) begin
      prod = v[k] * longint'(m_ds[k]) * top;
      x = 0;
      if (prod > 0) begin
        x = prod >>> 16;
        if (x > (top <<< 16)) x = top <<< 16;
      end
      p = x >>> 16;
      d[k] = x & 64'hFFFF;
      hi[k] = ((p + 1 > top) ? top : p + 1) * stride[k];
      lo[k] = p * stride[k];
    end
    gr = d[0] > d[1];
    gg = d[1] > d[2];
    gb = d[2] > d[0];
    ia = ((!gb && gr) ? hi[0] : lo[0]) + ((!gr && gg) ? hi[1] : lo[1])
       + ((!gg && gb) ? hi[2] : lo[2]);
    ib = ((!gr && gb) ? lo[0] : hi[0]) + ((!gg && gr) ? lo[1] : hi[1])
       + ((!gb && gg) ? lo[2] : hi[2]);
    i0 = lo[0] + lo[1] + lo[2];
    i1 = hi[0] + hi[1] + hi[2];
    rgmin = (d[0] < d[1]) ? d[0] : d[1];
    rgmax = (d[0] < d[1]) ? d[1] : d[0];
    x2 = (rgmin < d[2]) ? rgmin : d[2];
    mid = (rgmin < d[2]) ? d[2] : rgmin;
    x0 = (rgmax < d[2]) ? d[2] : rgmax;
    x1 = (rgmax < mid) ? rgmax : mid;
    w[0] = 65536 - x0;
    w[1] = x0 - x1;
    w[2] = x1 - x2;
    w[3] = x2;
    idx[0] = i0;
    idx[1] = ia;
    idx[2] = ib;
    idx[3] = i1;
    acc = '{0, 0, 0};
    for (int t = 0; t < 4; t++) begin
      acc[0] += w[t] * sx24(cube_r[idx[t]]);
      acc[1] += w[t] * sx24(cube_g[idx[t]]);
      acc[2] += w[t] * sx24(cube_b[idx[t]]);
    end
    res.r = 24'(round16(acc[0]));
    res.g = 24'(round16(acc[1]));
    res.b = 24'(round16(acc[2]));
    res.a = q.a;
    return res;
  endfunction

  task automatic apply_request(request_t q);
    if (q.cmd == CMD_CUBE_WR) begin
      if (q.tidx < CUBE_DEPTH) begin
        cube_r[q.tidx] = q.er;
        cube_g[q.tidx] = q.eg;
        cube_b[q.tidx] = q.eb;
      end
    end else if (q.cmd == CMD_SHAPER_WR) begin
      if (q.ch < 2'd3 && q.tidx < SHAPER_ENTRIES_MAX) shaper_tab[q.ch][q.tidx] = q.sv;
    end else if (q.cmd == CMD_PIXEL) begin
      graded_q.push_back(grade_pixel(q));
    end
  endtask

  always @(posedge clk) begin : driver
    logic take;
    if (rst_n) begin
      take = !in_valid || !in_stall;
      if (in_valid && !in_stall) apply_request(cur);
      if (take) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending_q.pop_front();
          command <= cur.cmd;
          red <= cur.r;
          green <= cur.g;
          blue <= cur.b;
          alpha <= cur.a;
          table_index <= cur.tidx;
          shaper_channel <= cur.ch;
          entry_red <= cur.er;
          entry_green <= cur.eg;
          entry_blue <= cur.eb;
          shaper_value <= cur.sv;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : holder
    if (hold_req != hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= hold_req;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    graded_t e;
    logic st;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (graded_q.size() == 0) begin
          errors++;
          $display("%0t unexpected pixel: expected none actual %h %h %h %h", $time,
                   out_red, out_green, out_blue, out_alpha);
        end else begin
          e = graded_q.pop_front();
          check_field("out_red", e.r, out_red);
          check_field("out_green", e.g, out_green);
          check_field("out_blue", e.b, out_blue);
          check_field("out_alpha", e.a, out_alpha);
        end
      end
      if (hold_left > 0) begin
        st = 1'b1;
      end else begin
        st = $urandom_range(99) < recv_idle;
      end
      out_stall <= st;
    end
  end

  function automatic request_t blank_request(logic [1:0] cmd);
    request_t q;
    q.cmd = cmd;
    q.r = 24'($urandom());
    q.g = 24'($urandom());
    q.b = 24'($urandom());
    q.a = 24'($urandom());
    q.tidx = 16'($urandom());
    q.ch = 2'($urandom());
    q.er = 24'($urandom());
    q.eg = 24'($urandom());
    q.eb = 24'($urandom());
    q.sv = 24'($urandom());
    return q;
  endfunction

  function automatic request_t pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b,
                                     logic [23:0] a);
    request_t q;
    q = blank_request(CMD_PIXEL);
    q.r = r;
    q.g = g;
    q.b = b;
    q.a = a;
    return q;
  endfunction

  function automatic logic [23:0] near_range();
    return 24'($signed($urandom_range(81920)) - 8192);
  endfunction

  function automatic request_t random_request();
    request_t q;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      q = pixel(near_range(), near_range(), near_range(), 24'($urandom()));
    end else if (pick < 75) begin
      q = blank_request(CMD_PIXEL);
    end else if (pick < 87) begin
      q = blank_request(CMD_CUBE_WR);
      if ($urandom_range(9) != 0) q.tidx = 16'($urandom_range(CUBE_DEPTH - 1));
    end else if (pick < 95) begin
      q = blank_request(CMD_SHAPER_WR);
      if ($urandom_range(9) != 0) begin
        q.tidx = 16'($urandom_range(SHAPER_ENTRIES_MAX - 1));
        q.ch = 2'($urandom_range(2));
      end
    end else begin
      q = blank_request(CMD_UNKNOWN);
    end
    return q;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LUT_SIZE:     m_lut = data[5:0];
      REG_SHAPER_SIZE:  m_ssz = data[12:0];
      REG_DSCALE_RED:   m_ds[0] = data[23:0];
      REG_DSCALE_GREEN: m_ds[1] = data[23:0];
      REG_DSCALE_BLUE:  m_ds[2] = data[23:0];
      REG_SHAPER_MIN:   m_smin = data;
      REG_SHAPER_SCALE: m_ssc = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || graded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    request_t q;
    int lut_sizes[8] = '{2, 33, 17, 0, 63, 9, 33, 5};
    int shaper_sizes[8] = '{0, 4096, 1, 2, 8191, 17, 0, 4096};
    logic [59:0] smin, ssc;
    logic [23:0] ds;
    int top;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < CUBE_DEPTH; i++) begin
      q = blank_request(CMD_CUBE_WR);
      q.tidx = 16'(i);
      pending_q.push_back(q);
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < SHAPER_ENTRIES_MAX; i++) begin
        q = blank_request(CMD_SHAPER_WR);
        q.tidx = 16'(i);
        q.ch = 2'(ch);
        pending_q.push_back(q);
      end
    end
    q = blank_request(CMD_CUBE_WR);
    q.tidx = '0;
    q.er = 24'h800000;
    q.eg = 24'h7FFFFF;
    q.eb = 24'h000000;
    pending_q.push_back(q);
    q = blank_request(CMD_CUBE_WR);
    q.tidx = 16'(CUBE_DEPTH);
    pending_q.push_back(q);
    q = blank_request(CMD_CUBE_WR);
    q.tidx = 16'hFFFF;
    pending_q.push_back(q);
    q = blank_request(CMD_SHAPER_WR);
    q.ch = 2'd3;
    q.tidx = '0;
    pending_q.push_back(q);
    q = blank_request(CMD_SHAPER_WR);
    q.ch = '0;
    q.tidx = 16'(SHAPER_ENTRIES_MAX);
    pending_q.push_back(q);
    pending_q.push_back(blank_request(CMD_UNKNOWN));
    pending_q.push_back(pixel('0, '0, '0, 24'h800000));
    pending_q.push_back(pixel(24'd65536, 24'd65536, 24'd65536, 24'h7FFFFF));
    pending_q.push_back(pixel(24'h800000, 24'h7FFFFF, 24'h800000, '0));
    pending_q.push_back(pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF));
    pending_q.push_back(pixel(24'd32768, 24'd32768, 24'd32768, 24'd1));
    pending_q.push_back(pixel(24'd32768, 24'd32768, 24'd1000, 24'd2));
    pending_q.push_back(pixel(24'd1000, 24'd32768, 24'd32768, 24'd3));
    pending_q.push_back(pixel(24'd40000, 24'd1000, 24'd40000, 24'd4));
    pending_q.push_back(pixel(24'd50000, 24'd30000, 24'd10000, 24'd5));
    pending_q.push_back(pixel(24'd10000, 24'd30000, 24'd50000, 24'd6));
    pending_q.push_back(pixel(24'd30000, 24'd50000, 24'd10000, 24'd7));
    pending_q.push_back(pixel(24'hFFFFFF, 24'd65535, 24'd2048, 24'd8));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      top = (shaper_sizes[ph] > 4096 ? 4096 : shaper_sizes[ph]) - 1;
      if (top < 0) top = 0;
      smin = '0;
      ssc = '0;
      for (int ch = 0; ch < 3; ch++) begin
        smin[20*ch +: 20] = 20'($signed($urandom_range(16384)) - 8192);
        ssc[20*ch +: 20] = 20'(top * 256 + $urandom_range(512));
      end
      if (ph == 4) begin
        smin = 60'({$urandom(), $urandom()});
        ssc = 60'({$urandom(), $urandom()});
      end
      if (ph == 7) ssc = {3{20'hFFFFF}};
      write_reg(REG_LUT_SIZE, 60'(lut_sizes[ph]));
      write_reg(REG_SHAPER_SIZE, 60'(shaper_sizes[ph]));
      for (int k = 0; k < 3; k++) begin
        if (ph == 3) ds = 24'd0;
        else if (ph == 4) ds = 24'hFFFFFF;
        else if (ph % 2 == 1) ds = 24'd65536;
        else ds = 24'($urandom_range(131072, 32768));
        write_reg(REG_DSCALE_RED + CFG_IDX_W'(k), 60'(ds));
      end
      write_reg(REG_SHAPER_MIN, smin);
      write_reg(REG_SHAPER_SCALE, ssc);

      case (ph % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 82; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 82; end
        default: begin send_idle = 36; recv_idle = 36; end
      endcase
      if (ph == 4) hold_req++;
      for (int half = 0; half < 2; half++) begin
        for (int i = 0; i < 110; i++) pending_q.push_back(random_request());
        drain();
      end
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/l3dt_pkg.sv
hw/rtl/l3dt_front.sv
hw/rtl/l3dt_queue.sv
hw/rtl/l3dt_shaper.sv
hw/rtl/l3dt_cube.sv
hw/rtl/lut3d_tetrahedral_with_shaper.sv
bench/tb_lut3d_tetrahedral_with_shaper.sv
